FILE: hdl/lru_pkg.sv
// Package for the LRU page replacement block.
// Holds shared constants and the control structs passed from the top level to each frame cell.
// No dependencies.
package lru_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 8;
  localparam int CFG_W         = 4;
  localparam int CNT_W         = 32;
  // wide enough for an occupancy of up to 64 frames
  localparam int OCC_W         = 7;
  localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(4);

  // per-cell position decode
  typedef struct packed {
    logic active;   // cell holds a resident page
    logic tail;     // most recently used slot
    logic append;   // first free slot
  } lru_sel_t;

  // request-wide control
  typedef struct packed {
    logic fire;     // request accepted this cycle
    logic full;     // every usable frame is resident
  } lru_op_t;

endpackage

FILE: hdl/lru_cell.sv
// One frame cell of the LRU ordered list: holds a page, compares it to the request,
// and shifts in its neighbor's page when the list closes up. Depends on lru_pkg.
module lru_cell import lru_pkg::*; #(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic [PAGE_BITS-1:0] pg,
  input  lru_op_t              op,
  input  lru_sel_t             sel,
  input  logic                 hit_any,
  input  logic                 seen_in,
  input  logic [PAGE_BITS-1:0] nbr_page,
  output logic                 seen_out,
  output logic [PAGE_BITS-1:0] page_out
);

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;
  logic                 match;
  logic                 evict;
  logic                 shift;

  assign match    = sel.active && (page_r == pg);
  assign seen_out = seen_in | match;
  assign evict    = op.full & ~hit_any;
  // close the gap left by the hit page, or by the evicted LRU page
  assign shift    = sel.active & (evict | (hit_any & seen_out));
  assign page_out = page_r;

  always_comb begin
    page_nxt = page_r;
    if (sel.tail && (hit_any || evict)) begin
      page_nxt = pg;
    end else if (shift) begin
      page_nxt = nbr_page;
    end else if (sel.append && !hit_any && !op.full) begin
      page_nxt = pg;
    end
  end

  always_ff @(posedge clk) begin
    if (op.fire) begin
      page_r <= page_nxt;
    end
  end

endmodule

FILE: hdl/lru_page_replacement.sv
// LRU page replacement: a chain of FRAMES cells kept in least to most recently used order.
// The result is registered, valid the cycle after accept; 1 request per cycle is taken while
// the output is not stalled, set by the single pass of compare and shift through the cells.
// Reset (synchronous, rst_n low): list empty, fault total 0, num_frames 4, no result pending;
// the input is stalled while rst_n is low.
// A write to num_frames empties the list; the fault total is kept.
module lru_page_replacement import lru_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_num_frames,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] in_page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_fault,
  output logic                 out_evict_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [CNT_W-1:0]     out_fault_total
);

  logic [CFG_W-1:0]     num_frames_r;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 fault_r;
  logic                 evict_r;
  logic [PAGE_BITS-1:0] evpage_r;

  logic [OCC_W-1:0]     limit;
  logic [OCC_W-1:0]     occ_eff;
  logic                 fire;
  logic                 hit;
  logic                 evict;
  lru_op_t              op;
  lru_sel_t             sel   [FRAMES];
  logic                 seen  [FRAMES+1];
  logic [PAGE_BITS-1:0] pages [FRAMES+1];

  assign in_stall = ~rst_n | (out_valid_r & out_stall);
  assign fire     = in_valid & ~in_stall;

  always_comb begin
    if (num_frames_r == '0) begin
      limit = OCC_W'(1);
    end else if (OCC_W'(num_frames_r) > OCC_W'(FRAMES)) begin
      limit = OCC_W'(FRAMES);
    end else begin
      limit = OCC_W'(num_frames_r);
    end
    occ_eff = (occ_r > limit) ? limit : occ_r;
  end

  assign op.fire = fire;
  assign op.full = (occ_eff == limit);

  assign seen[0]       = 1'b0;
  assign pages[FRAMES] = '0;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    assign sel[k].active = (OCC_W'(k) < occ_eff);
    assign sel[k].tail   = (OCC_W'(k + 1) == occ_eff);
    assign sel[k].append = (OCC_W'(k) == occ_eff);

    lru_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .pg       (in_page),
      .op       (op),
      .sel      (sel[k]),
      .hit_any  (hit),
      .seen_in  (seen[k]),
      .nbr_page (pages[k+1]),
      .seen_out (seen[k+1]),
      .page_out (pages[k])
    );
  end

  assign hit   = seen[FRAMES];
  assign evict = op.full & ~hit;

  always_comb begin
    occ_nxt = occ_eff;
    cnt_nxt = cnt_r;
    if (!hit) begin
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (!op.full) begin
        occ_nxt = occ_eff + OCC_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= NUM_FRAMES_RST;
      occ_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        num_frames_r <= cfg_num_frames;
        occ_r        <= '0;
      end else if (fire) begin
        occ_r <= occ_nxt;
      end
      if (fire) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fault_r  <= ~hit;
      evict_r  <= evict;
      evpage_r <= evict ? pages[0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fault        = fault_r;
  assign out_evict_valid  = evict_r;
  assign out_evicted_page = evpage_r;
  assign out_fault_total  = cnt_r;

endmodule

FILE: dv/lru_page_replacement_test.sv
// Self-checking testbench for lru_page_replacement: random page references and
// frame-count settings, checked against an LRU list kept in a queue.
// Depends on lru_pkg and the lru_page_replacement RTL.
`timescale 1ns / 1ps

module lru_page_replacement_test;
  import lru_pkg::*;

  typedef logic [PAGE_BITS_DEF-1:0] page_t;

  typedef struct packed {
    logic             fault;
    logic             evict_valid;
    page_t            evicted_page;
    logic [CNT_W-1:0] fault_total;
  } lru_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_num_frames = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  page_t            in_page = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_fault;
  logic             out_evict_valid;
  page_t            out_evicted_page;
  logic [CNT_W-1:0] out_fault_total;

  // pages waiting to be sent, results waiting to come back
  page_t       page_refs[$];
  lru_result_t pending_results[$];

  // model state: resident pages, least recently used at the front
  page_t            resident[$];
  logic [CFG_W-1:0] frames_cfg = NUM_FRAMES_RST;
  logic [CNT_W-1:0] fault_cnt = '0;

  bit calm = 1'b0;      // no idling on either side
  int hold_req = 0;     // receiver hold-off length, picked up by the monitor
  int hold_left = 0;
  int errors = 0;
  int n_refs = 0, n_hits = 0, n_faults = 0, n_evicts = 0, n_settings = 0;

  lru_page_replacement uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_num_frames   (cfg_num_frames),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fault        (out_fault),
    .out_evict_valid  (out_evict_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic lru_result_t lru_lookup(page_t pg);
    lru_result_t r;
    int          limit;
    int          hit_at;
    r = '0;
    hit_at = -1;
    // zero acts as one frame, anything past the array size as the full array
    limit = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES_DEF) ? FRAMES_DEF : frames_cfg;
    foreach (resident[k])
      if (hit_at < 0 && resident[k] == pg) hit_at = k;
    n_refs++;
    if (hit_at >= 0) begin
      resident.delete(hit_at);
      n_hits++;
    end else begin
      r.fault = 1'b1;
      n_faults++;
      if (fault_cnt != '1) fault_cnt++;
      if (resident.size() >= limit) begin
        r.evict_valid = 1'b1;
        r.evicted_page = resident.pop_front();
        n_evicts++;
      end
    end
    resident.push_back(pg);
    r.fault_total = fault_cnt;
    return r;
  endfunction

  function automatic page_t next_page(page_t base, int span);
    if ($urandom_range(99) < 12) return page_t'($urandom_range(255));
    return page_t'(base + $urandom_range(span));
  endfunction

  // driver: payload only moves when the current request is taken or none is up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) pending_results.push_back(lru_lookup(in_page));
      if (page_refs.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
        in_valid <= 1'b1;
        in_page <= page_refs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    lru_result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0b %0b %0h %0d", $time,
                   out_fault, out_evict_valid, out_evicted_page, out_fault_total);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_fault !== exp_r.fault) begin
            $display("%0t: fault expected %0b actual %0b", $time, exp_r.fault, out_fault);
            errors++;
          end
          if (out_evict_valid !== exp_r.evict_valid) begin
            $display("%0t: evict_valid expected %0b actual %0b", $time,
                     exp_r.evict_valid, out_evict_valid);
            errors++;
          end
          if (out_evicted_page !== exp_r.evicted_page) begin
            $display("%0t: evicted_page expected %0h actual %0h", $time,
                     exp_r.evicted_page, out_evicted_page);
            errors++;
          end
          if (out_fault_total !== exp_r.fault_total) begin
            $display("%0t: fault_total expected %0d actual %0d", $time,
                     exp_r.fault_total, out_fault_total);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 25);
      end
    end
  end

  task automatic wait_drained;
    @(negedge clk);
    while (page_refs.size() != 0 || in_valid || pending_results.size() != 0) @(negedge clk);
  endtask

  // called only with nothing in flight
  task automatic write_frames(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_num_frames <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_cfg = v;
    resident.delete();
    n_settings++;
    @(negedge clk);
  endtask

  task automatic push_random(int count, int span);
    page_t base;
    base = page_t'($urandom_range(255));
    repeat (count) page_refs.push_back(next_page(base, span));
  endtask

  initial begin
    logic [CFG_W-1:0] settings[12];
    settings = '{4'd4, 4'd1, 4'd0, 4'd15, 4'd8, 4'd2,
                 4'd9, 4'd5, 4'd3, 4'd7, 4'd6, 4'd8};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    n_settings = 1;

    // reset value of four frames: hits, a reorder, then eviction of page 0
    page_refs = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd2, 8'd255, 8'd3, 8'd128};
    push_random(75, 6);
    wait_drained();

    for (int p = 1; p < 12; p++) begin
      write_frames(settings[p]);
      if (settings[p] == 4'd1) page_refs = '{8'd7, 8'd7, 8'd8, 8'd7};
      if (settings[p] == 4'd0) page_refs = '{8'd9, 8'd9, 8'd10, 8'd9};
      if (settings[p] == 4'd15) begin
        // nine distinct pages overflow eight frames, then one hit
        for (int k = 0; k < 9; k++) page_refs.push_back(page_t'(8'hf0 + k));
        page_refs.push_back(8'hf1);
      end
      calm = (p == 4);
      // sender keeps offering while the receiver holds off
      if (p == 9) hold_req = 200;
      push_random(75, int'(settings[p]) + 3);
      wait_drained();
    end
    calm = 1'b0;

    repeat (4) @(posedge clk);
    $display("Covered %0d page references over %0d frame-count settings", n_refs, n_settings);
    $display("  %0d hits, %0d faults, %0d evictions", n_hits, n_faults, n_evicts);
    if (errors == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
hdl/lru_pkg.sv
hdl/lru_cell.sv
hdl/lru_page_replacement.sv
dv/lru_page_replacement_test.sv
